>>> rtl/bmppau_pkg.sv
`default_nettype none

package bmppau_pkg;

  // Widths fixed by the register map and the result fields
  localparam int unsigned DimRegW   = 12;
  localparam int unsigned OffRegW   = 12;
  localparam int unsigned CfgDataW  = 12;
  localparam int unsigned CfgIndexW = 3;
  localparam int unsigned CoordW    = 13;
  localparam int unsigned ByteW     = 8;
  localparam int unsigned ArgbW     = 32;

  localparam logic [DimRegW-1:0] ImageWidthRst  = 12'd800;
  localparam logic [DimRegW-1:0] ImageHeightRst = 12'd480;

  typedef enum logic [CfgIndexW-1:0] {
    CFG_IMAGE_WIDTH    = 3'd0,
    CFG_WIDTH_MIRRORED = 3'd1,
    CFG_IMAGE_HEIGHT   = 3'd2,
    CFG_ROWS_TOP_DOWN  = 3'd3,
    CFG_ALPHA_PRESENT  = 3'd4,
    CFG_OFFSET_X       = 3'd5,
    CFG_OFFSET_Y       = 3'd6
  } cfg_index_e;

  // Which byte of the pixel is expected next
  typedef enum logic [1:0] {
    PH_BLUE  = 2'd0,
    PH_GREEN = 2'd1,
    PH_RED   = 2'd2,
    PH_ALPHA = 2'd3
  } byte_phase_e;

endpackage

`default_nettype wire

>>> rtl/bmp_pixel_array_unpacker_unit.sv
// A pixel's result is registered and offered in the cycle after the transfer of its last byte.
// One byte per cycle, back to back, while pixels are taken as offered;
// a pixel held in the single result register and not taken stalls every byte until it is.
// Reset (asynchronous, active low) restores the default registers (800 x 480,
// bottom-up, unmirrored, 24-bit, zero offsets) and starts at the first byte of an image.
`default_nettype none

module bmp_pixel_array_unpacker_unit #(
  parameter int unsigned MAX_DIMENSION = 2048
) (
  input  wire logic                                   clk_i,
  input  wire logic                                   rst_ni,
  // configuration write port
  input  wire logic                                   cfg_we_i,
  input  wire logic [bmppau_pkg::CfgIndexW-1:0]       cfg_index_i,
  input  wire logic [bmppau_pkg::CfgDataW-1:0]        cfg_wdata_i,
  // byte stream in
  input  wire logic                                   in_valid_i,
  output logic                                        in_ready_o,
  input  wire logic [bmppau_pkg::ByteW-1:0]           pixel_byte_i,
  // pixel out
  output logic                                        out_valid_o,
  input  wire logic                                   out_ready_i,
  output logic signed [bmppau_pkg::CoordW-1:0]        screen_x_o,
  output logic signed [bmppau_pkg::CoordW-1:0]        screen_y_o,
  output logic [bmppau_pkg::ArgbW-1:0]                argb_color_o,
  output logic                                        last_pixel_o
);

  // Counter holds 0 .. MAX_DIMENSION-1; effective dimension holds 1 .. MAX_DIMENSION
  localparam int unsigned CntW  = $clog2(MAX_DIMENSION);
  localparam int unsigned DimW  = CntW + 1;
  localparam int unsigned RegW  = bmppau_pkg::DimRegW;
  localparam int unsigned CmpW  = (DimW > RegW) ? DimW : RegW;
  localparam int unsigned CrdW  = bmppau_pkg::CoordW;
  // Coordinate maths runs at least CoordW wide and wraps on truncation
  localparam int unsigned ExtW  = (DimW > CrdW) ? DimW : CrdW;
  localparam int unsigned OffW  = bmppau_pkg::OffRegW;
  localparam int unsigned ByteW = bmppau_pkg::ByteW;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [RegW-1:0] image_width_q, image_height_q;
  logic            width_mirrored_q, rows_top_down_q, alpha_present_q;
  logic [OffW-1:0] offset_x_q, offset_y_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      image_width_q    <= bmppau_pkg::ImageWidthRst;
      image_height_q   <= bmppau_pkg::ImageHeightRst;
      width_mirrored_q <= 1'b0;
      rows_top_down_q  <= 1'b0;
      alpha_present_q  <= 1'b0;
      offset_x_q       <= '0;
      offset_y_q       <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        bmppau_pkg::CFG_IMAGE_WIDTH:    image_width_q    <= cfg_wdata_i[RegW-1:0];
        bmppau_pkg::CFG_WIDTH_MIRRORED: width_mirrored_q <= cfg_wdata_i[0];
        bmppau_pkg::CFG_IMAGE_HEIGHT:   image_height_q   <= cfg_wdata_i[RegW-1:0];
        bmppau_pkg::CFG_ROWS_TOP_DOWN:  rows_top_down_q  <= cfg_wdata_i[0];
        bmppau_pkg::CFG_ALPHA_PRESENT:  alpha_present_q  <= cfg_wdata_i[0];
        bmppau_pkg::CFG_OFFSET_X:       offset_x_q       <= cfg_wdata_i[OffW-1:0];
        bmppau_pkg::CFG_OFFSET_Y:       offset_y_q       <= cfg_wdata_i[OffW-1:0];
        default: ; // unmapped index: write dropped
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Effective dimensions: zero acts as one, oversize clamps to MAX_DIMENSION
  // ---------------------------------------------------------------------------
  logic [CmpW-1:0] width_ext, height_ext;
  logic [DimW-1:0] width_eff, height_eff;
  logic [CntW-1:0] last_col, last_row;

  always_comb begin
    width_ext  = CmpW'(image_width_q);
    height_ext = CmpW'(image_height_q);

    if (width_ext == '0) begin
      width_eff = DimW'(1);
    end else if (width_ext > CmpW'(MAX_DIMENSION)) begin
      width_eff = DimW'(MAX_DIMENSION);
    end else begin
      width_eff = width_ext[DimW-1:0];
    end

    if (height_ext == '0) begin
      height_eff = DimW'(1);
    end else if (height_ext > CmpW'(MAX_DIMENSION)) begin
      height_eff = DimW'(MAX_DIMENSION);
    end else begin
      height_eff = height_ext[DimW-1:0];
    end

    last_col = CntW'(width_eff - DimW'(1));
    last_row = CntW'(height_eff - DimW'(1));
  end

  // ---------------------------------------------------------------------------
  // Gathering state
  // ---------------------------------------------------------------------------
  bmppau_pkg::byte_phase_e phase_q, phase_d;
  logic [CntW-1:0]  col_cnt_q, col_cnt_d;
  logic [CntW-1:0]  row_cnt_q, row_cnt_d;
  logic [1:0]       pad_left_q, pad_left_d;
  logic [ByteW-1:0] blue_q, green_q, red_q;
  logic [ByteW-1:0] blue_d, green_d, red_d;

  // result register
  logic                          out_valid_q, out_valid_d;
  logic signed [CrdW-1:0]        screen_x_q, screen_x_d;
  logic signed [CrdW-1:0]        screen_y_q, screen_y_d;
  logic [bmppau_pkg::ArgbW-1:0]  argb_q, argb_d;
  logic                          last_q, last_d;

  logic            in_xfer, emit;
  logic            row_end, img_end;
  logic [ByteW-1:0] alpha_byte;
  logic [ExtW-1:0] col_pos, row_pos, sx_sum, sy_sum;

  // Accept whenever the result slot is empty or being drained this cycle
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_xfer    = in_valid_i && in_ready_o;

  always_comb begin
    phase_d    = phase_q;
    col_cnt_d  = col_cnt_q;
    row_cnt_d  = row_cnt_q;
    pad_left_d = pad_left_q;
    blue_d     = blue_q;
    green_d    = green_q;
    red_d      = red_q;
    emit       = 1'b0;
    alpha_byte = '0;

    row_end = (col_cnt_q >= last_col);
    img_end = row_end && (row_cnt_q >= last_row);

    // column / row with orientation; wraps modulo 2^ExtW, truncated to 13 bits later
    col_pos = width_mirrored_q ? (ExtW'(last_col) - ExtW'(col_cnt_q)) : ExtW'(col_cnt_q);
    row_pos = rows_top_down_q  ? ExtW'(row_cnt_q) : (ExtW'(last_row) - ExtW'(row_cnt_q));

    if (in_xfer) begin
      if (pad_left_q != 2'd0) begin
        pad_left_d = pad_left_q - 2'd1;   // row padding: drop the byte
      end else begin
        case (phase_q)
          bmppau_pkg::PH_BLUE: begin
            blue_d  = pixel_byte_i;
            phase_d = bmppau_pkg::PH_GREEN;
          end
          bmppau_pkg::PH_GREEN: begin
            green_d = pixel_byte_i;
            phase_d = bmppau_pkg::PH_RED;
          end
          bmppau_pkg::PH_RED: begin
            red_d = pixel_byte_i;
            if (alpha_present_q) begin
              phase_d = bmppau_pkg::PH_ALPHA;
            end else begin
              phase_d = bmppau_pkg::PH_BLUE;
              emit    = 1'b1;
            end
          end
          default: begin
            // alpha phase: fourth byte is alpha even if 32-bit mode was cleared meanwhile
            alpha_byte = pixel_byte_i;
            phase_d    = bmppau_pkg::PH_BLUE;
            emit       = 1'b1;
          end
        endcase

        if (emit) begin
          if (row_end) begin
            col_cnt_d  = '0;
            row_cnt_d  = img_end ? '0 : row_cnt_q + CntW'(1);
            // 24-bit rows of w pixels need (w mod 4) pad bytes to reach a word boundary
            pad_left_d = alpha_present_q ? 2'd0 : width_eff[1:0];
          end else begin
            col_cnt_d = col_cnt_q + CntW'(1);
          end
        end
      end
    end
  end

  always_comb begin
    sx_sum = {{(ExtW-OffW){offset_x_q[OffW-1]}}, offset_x_q} + col_pos;
    sy_sum = {{(ExtW-OffW){offset_y_q[OffW-1]}}, offset_y_q} + row_pos;

    out_valid_d = out_valid_q && !out_ready_i;
    screen_x_d  = screen_x_q;
    screen_y_d  = screen_y_q;
    argb_d      = argb_q;
    last_d      = last_q;

    if (emit) begin
      out_valid_d = 1'b1;
      screen_x_d  = signed'(sx_sum[CrdW-1:0]);
      screen_y_d  = signed'(sy_sum[CrdW-1:0]);
      argb_d      = {alpha_byte, red_d, green_q, blue_q};
      last_d      = img_end;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= bmppau_pkg::PH_BLUE;
      col_cnt_q   <= '0;
      row_cnt_q   <= '0;
      pad_left_q  <= 2'd0;
      blue_q      <= '0;
      green_q     <= '0;
      red_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      col_cnt_q   <= col_cnt_d;
      row_cnt_q   <= row_cnt_d;
      pad_left_q  <= pad_left_d;
      blue_q      <= blue_d;
      green_q     <= green_d;
      red_q       <= red_d;
      out_valid_q <= out_valid_d;
    end
  end

  // result payload, no reset needed
  always_ff @(posedge clk_i) begin
    screen_x_q <= screen_x_d;
    screen_y_q <= screen_y_d;
    argb_q     <= argb_d;
    last_q     <= last_d;
  end

  assign out_valid_o  = out_valid_q;
  assign screen_x_o   = screen_x_q;
  assign screen_y_o   = screen_y_q;
  assign argb_color_o = argb_q;
  assign last_pixel_o = last_q;

endmodule

`default_nettype wire
